FILE: sv/cau_pkg.sv
// Shared types and constants of the complex arithmetic unit.
package cau_pkg;

  localparam int IO_W = 32;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef struct packed {
    logic valid;
    op_e  op;
    logic neg_re;
    logic neg_im;
    logic big_re;
    logic big_im;
    logic dz;
  } ctl_t;

endpackage

FILE: sv/complex_arith_unit.sv
// Top level of the complex arithmetic unit: front stages, magnitude, divider chain and saturation.
//
// Each input word carries an opcode in tuser (add, subtract, multiply, divide) and two
// complex operands in tdata, every part a signed fixed-point value of DATA_WIDTH bits
// with FRAC_BITS fractional bits, taken from the low bits of its 32-bit lane.
// Each output word carries the real and imaginary result parts in tdata, saturated
// and sign-extended to 32 bits, with the overflow and divide-by-zero flags in tuser.
// The block is a single pipeline in which every operation takes the same path.
// Each input word passes in order through five stages for the operand register,
// products, sums, magnitudes and divider set-up, one restoring division stage per
// quotient bit (DATA_WIDTH + 1 of them), and the output register. A new word is
// accepted in every cycle in which the pipeline is not held; throughput is then one
// word per cycle. When the receiver stalls with a result held, the whole pipeline holds
// and tready falls, so no word is lost or repeated. Reset clears every valid bit.
module complex_arith_unit #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [127:0] s_axis_tdata_i,  // a_re, a_im, b_re, b_im
  input  logic [1:0]   s_axis_tuser_i,  // opcode
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [63:0]  m_axis_tdata_o,  // res_re, res_im
  output logic [1:0]   m_axis_tuser_o   // overflow, div_zero
);
  import cau_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2 * W + 1;
  localparam int RW = 3 * W + F + 2;
  localparam int NS = W + 1;

  logic en;

  ctl_t                 ctl3, ctl4_d, ctl4_q, ctl5_d, ctl5_q;
  logic signed [PW-1:0] sre3, sim3;
  logic [2*W-1:0]       d3, d4_q, d5_q;
  logic [PW-1:0]        mre4_q, mim4_q;
  logic [RW-1:0]        r_re5_q, r_im5_q;
  logic [W:0]           q_re5_q, q_im5_q;

  ctl_t            ctl_s [NS+1];
  logic [2*W-1:0]  d_s   [NS+1];
  logic [RW-1:0]   rre_s [NS+1];
  logic [RW-1:0]   rim_s [NS+1];
  logic [W:0]      qre_s [NS+1];
  logic [W:0]      qim_s [NS+1];

  logic                out_valid_q, ovf_q, dz_q;
  logic signed [W-1:0] res_re_d, res_im_d;
  logic [IO_W-1:0]     res_re_q, res_im_q;
  logic                ovf_re, ovf_im;

  assign en              = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  cau_front #(.W(W)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid_i),
    .op_i    (op_e'(s_axis_tuser_i)),
    .a_re_i  (s_axis_tdata_i[W-1:0]),
    .a_im_i  (s_axis_tdata_i[32+W-1:32]),
    .b_re_i  (s_axis_tdata_i[64+W-1:64]),
    .b_im_i  (s_axis_tdata_i[96+W-1:96]),
    .ctl_o   (ctl3),
    .sre_o   (sre3),
    .sim_o   (sim3),
    .d_o     (d3)
  );

  always_comb begin
    ctl4_d        = ctl3;
    ctl4_d.neg_re = sre3[PW-1];
    ctl4_d.neg_im = sim3[PW-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl4_q <= '0;
      ctl5_q <= '0;
    end else if (en) begin
      ctl4_q <= ctl4_d;
      ctl5_q <= ctl5_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mre4_q <= sre3[PW-1] ? (~sre3 + 1'b1) : sre3;
      mim4_q <= sim3[PW-1] ? (~sim3 + 1'b1) : sim3;
      d4_q   <= d3;
    end
  end

  logic [RW-1:0] num_re, num_im, dtop;
  logic [PW-1:0] val_re, val_im;
  logic          isdiv;

  always_comb begin
    isdiv  = (ctl4_q.op == OP_DIV);
    num_re = RW'(mre4_q) << F;
    num_im = RW'(mim4_q) << F;
    dtop   = RW'(d4_q) << (W + 1);
    val_re = (ctl4_q.op == OP_MUL) ? (mre4_q >> F) : mre4_q;
    val_im = (ctl4_q.op == OP_MUL) ? (mim4_q >> F) : mim4_q;
    ctl5_d = ctl4_q;
    if (isdiv) begin
      ctl5_d.big_re = (num_re >= dtop);
      ctl5_d.big_im = (num_im >= dtop);
      ctl5_d.dz     = (d4_q == '0);
    end else begin
      ctl5_d.big_re = |val_re[PW-1:W+1];
      ctl5_d.big_im = |val_im[PW-1:W+1];
      ctl5_d.dz     = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d5_q    <= d4_q;
      r_re5_q <= num_re;
      r_im5_q <= num_im;
      q_re5_q <= isdiv ? '0 : val_re[W:0];
      q_im5_q <= isdiv ? '0 : val_im[W:0];
    end
  end

  assign ctl_s[0] = ctl5_q;
  assign d_s[0]   = d5_q;
  assign rre_s[0] = r_re5_q;
  assign rim_s[0] = r_im5_q;
  assign qre_s[0] = q_re5_q;
  assign qim_s[0] = q_im5_q;

  for (genvar k = 0; k < NS; k++) begin : g_div
    cau_div_step #(.W(W), .RW(RW), .SHIFT(W - k)) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (ctl_s[k]),
      .d_i    (d_s[k]),
      .r_re_i (rre_s[k]),
      .r_im_i (rim_s[k]),
      .q_re_i (qre_s[k]),
      .q_im_i (qim_s[k]),
      .ctl_o  (ctl_s[k+1]),
      .d_o    (d_s[k+1]),
      .r_re_o (rre_s[k+1]),
      .r_im_o (rim_s[k+1]),
      .q_re_o (qre_s[k+1]),
      .q_im_o (qim_s[k+1])
    );
  end

  ctl_t       cf;
  logic [W:0] qr, qi;
  logic       nr, ni, br, bi;

  always_comb begin
    cf = ctl_s[NS];
    qr = qre_s[NS];
    qi = qim_s[NS];
    nr = cf.neg_re && !cf.dz;
    ni = cf.neg_im && !cf.dz;
    br = cf.big_re || cf.dz;
    bi = cf.big_im || cf.dz;
    if (!nr) begin
      ovf_re   = br || qr[W] || qr[W-1];
      res_re_d = ovf_re ? {1'b0, {(W-1){1'b1}}} : signed'(qr[W-1:0]);
    end else begin
      ovf_re   = br || qr[W] || (qr[W-1] && (|qr[W-2:0]));
      res_re_d = ovf_re ? {1'b1, {(W-1){1'b0}}} : signed'(~qr[W-1:0] + 1'b1);
    end
    if (!ni) begin
      ovf_im   = bi || qi[W] || qi[W-1];
      res_im_d = ovf_im ? {1'b0, {(W-1){1'b1}}} : signed'(qi[W-1:0]);
    end else begin
      ovf_im   = bi || qi[W] || (qi[W-1] && (|qi[W-2:0]));
      res_im_d = ovf_im ? {1'b1, {(W-1){1'b0}}} : signed'(~qi[W-1:0] + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= cf.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_re_q <= IO_W'(res_re_d);
      res_im_q <= IO_W'(res_im_d);
      ovf_q    <= ovf_re || ovf_im;
      dz_q     <= cf.dz;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {res_im_q, res_re_q};
  assign m_axis_tuser_o  = {dz_q, ovf_q};

endmodule

FILE: sv/cau_front.sv
// Front stages of the complex arithmetic unit: operand register, products and sums.
module cau_front #(
  parameter int W = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  cau_pkg::op_e          op_i,
  input  logic signed [W-1:0]   a_re_i,
  input  logic signed [W-1:0]   a_im_i,
  input  logic signed [W-1:0]   b_re_i,
  input  logic signed [W-1:0]   b_im_i,
  output cau_pkg::ctl_t         ctl_o,
  output logic signed [2*W:0]   sre_o,
  output logic signed [2*W:0]   sim_o,
  output logic [2*W-1:0]        d_o
);
  import cau_pkg::*;

  localparam int PW = 2 * W + 1;

  ctl_t                 ctl1_q, ctl2_q, ctl3_q;
  logic signed [W-1:0]  ar_q, ai_q, br_q, bi_q;
  logic signed [2*W-1:0] prr_q, pii_q, pri_q, pir_q, sqr_q, sqi_q;
  logic signed [W:0]    sum_re_q, sum_im_q;
  logic signed [PW-1:0] sre_d, sim_d, sre_q, sim_q;
  logic [2*W-1:0]       d_d, d_q;
  ctl_t                 ctl1_d;

  always_comb begin
    ctl1_d       = '0;
    ctl1_d.valid = valid_i;
    ctl1_d.op    = op_i;
  end

  always_comb begin
    unique case (ctl2_q.op)
      OP_ADD, OP_SUB: begin
        sre_d = PW'(sum_re_q);
        sim_d = PW'(sum_im_q);
      end
      OP_MUL: begin
        sre_d = PW'(prr_q) - PW'(pii_q);
        sim_d = PW'(pri_q) + PW'(pir_q);
      end
      default: begin
        sre_d = PW'(prr_q) + PW'(pii_q);
        sim_d = PW'(pir_q) - PW'(pri_q);
      end
    endcase
    d_d = $unsigned(sqr_q) + $unsigned(sqi_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      ctl3_q <= '0;
    end else if (en_i) begin
      ctl1_q <= ctl1_d;
      ctl2_q <= ctl1_q;
      ctl3_q <= ctl2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ar_q     <= a_re_i;
      ai_q     <= a_im_i;
      br_q     <= b_re_i;
      bi_q     <= b_im_i;
      prr_q    <= ar_q * br_q;
      pii_q    <= ai_q * bi_q;
      pri_q    <= ar_q * bi_q;
      pir_q    <= ai_q * br_q;
      sqr_q    <= br_q * br_q;
      sqi_q    <= bi_q * bi_q;
      sum_re_q <= (ctl1_q.op == OP_SUB) ? ((W+1)'(ar_q) - (W+1)'(br_q))
                                        : ((W+1)'(ar_q) + (W+1)'(br_q));
      sum_im_q <= (ctl1_q.op == OP_SUB) ? ((W+1)'(ai_q) - (W+1)'(bi_q))
                                        : ((W+1)'(ai_q) + (W+1)'(bi_q));
      sre_q    <= sre_d;
      sim_q    <= sim_d;
      d_q      <= d_d;
    end
  end

  assign ctl_o = ctl3_q;
  assign sre_o = sre_q;
  assign sim_o = sim_q;
  assign d_o   = d_q;

endmodule

FILE: sv/cau_div_step.sv
// One restoring division step for the real and imaginary lanes.
module cau_div_step #(
  parameter int W     = 32,
  parameter int RW    = 114,
  parameter int SHIFT = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  cau_pkg::ctl_t     ctl_i,
  input  logic [2*W-1:0]    d_i,
  input  logic [RW-1:0]     r_re_i,
  input  logic [RW-1:0]     r_im_i,
  input  logic [W:0]        q_re_i,
  input  logic [W:0]        q_im_i,
  output cau_pkg::ctl_t     ctl_o,
  output logic [2*W-1:0]    d_o,
  output logic [RW-1:0]     r_re_o,
  output logic [RW-1:0]     r_im_o,
  output logic [W:0]        q_re_o,
  output logic [W:0]        q_im_o
);
  import cau_pkg::*;

  ctl_t            ctl_q;
  logic [2*W-1:0]  d_q;
  logic [RW-1:0]   dsh, r_re_d, r_im_d, r_re_q, r_im_q;
  logic [W:0]      q_re_d, q_im_d, q_re_q, q_im_q;
  logic            div;

  always_comb begin
    dsh    = RW'(d_i) << SHIFT;
    div    = (ctl_i.op == OP_DIV);
    r_re_d = r_re_i;
    r_im_d = r_im_i;
    q_re_d = q_re_i;
    q_im_d = q_im_i;
    if (div && (r_re_i >= dsh)) begin
      r_re_d        = r_re_i - dsh;
      q_re_d[SHIFT] = 1'b1;
    end
    if (div && (r_im_i >= dsh)) begin
      r_im_d        = r_im_i - dsh;
      q_im_d[SHIFT] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q    <= d_i;
      r_re_q <= r_re_d;
      r_im_q <= r_im_d;
      q_re_q <= q_re_d;
      q_im_q <= q_im_d;
    end
  end

  assign ctl_o  = ctl_q;
  assign d_o    = d_q;
  assign r_re_o = r_re_q;
  assign r_im_o = r_im_q;
  assign q_re_o = q_re_q;
  assign q_im_o = q_im_q;

endmodule

FILE: tb/sv/cau_checker.sv
// Checker for the complex arithmetic unit: predicts each result and compares it.
module cau_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  input  logic         s_axis_tready_i,
  input  logic [127:0] s_axis_tdata_i,
  input  logic [1:0]   s_axis_tuser_i,
  input  logic         m_axis_tvalid_i,
  input  logic         m_axis_tready_i,
  input  logic [63:0]  m_axis_tdata_i,
  input  logic [1:0]   m_axis_tuser_i,
  output int           fail_count_o,
  output int           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import cau_pkg::*;

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic        ovf;
    logic        dz;
  } cplx_res_t;

  cplx_res_t result_q[$];

  function automatic logic [63:0] to_magnitude(logic [63:0] s, output logic neg);
    if (s == 64'h8000_0000_0000_0000) begin
      neg = 1'b0;
      return s;
    end
    neg = s[63];
    return neg ? -s : s;
  endfunction

  function automatic logic [31:0] clamp(logic neg, logic [63:0] mag, inout logic ovf);
    if (!neg) begin
      if (mag > 64'h7FFF_FFFF) begin
        ovf = 1'b1;
        mag = 64'h7FFF_FFFF;
      end
      return mag[31:0];
    end
    if (mag > 64'h8000_0000) begin
      ovf = 1'b1;
      mag = 64'h8000_0000;
    end
    return 32'(-mag);
  endfunction

  function automatic logic [63:0] scaled_quotient(logic [63:0] mag, logic [63:0] d);
    logic [63:0] qi, r, frac;
    logic        carry;
    qi = mag / d;
    r = mag % d;
    frac = '0;
    if (qi >= 64'h1_0000_0000) return '1;
    for (int i = 0; i < 16; i++) begin
      carry = r[63];
      r = r << 1;
      frac = frac << 1;
      if (carry || r >= d) begin
        r = r - d;
        frac[0] = 1'b1;
      end
    end
    return (qi << 16) | frac;
  endfunction

  function automatic cplx_res_t compute_complex(op_e op, logic [127:0] d);
    logic signed [63:0] ar, ai, br, bi;
    logic [63:0] sre, sim, mre, mim, xr, xi, dv;
    logic        nre, nim, ovf;
    cplx_res_t   r;
    ar = signed'(d[31:0]);
    ai = signed'(d[63:32]);
    br = signed'(d[95:64]);
    bi = signed'(d[127:96]);
    ovf = 1'b0;
    r.dz = 1'b0;
    case (op)
      OP_ADD: begin
        sre = ar + br;
        sim = ai + bi;
      end
      OP_SUB: begin
        sre = ar - br;
        sim = ai - bi;
      end
      OP_MUL: begin
        sre = ar * br - ai * bi;
        sim = ar * bi + ai * br;
      end
      default: begin
        sre = ar * br + ai * bi;
        sim = ai * br - ar * bi;
      end
    endcase
    mre = to_magnitude(sre, nre);
    mim = to_magnitude(sim, nim);
    if (op == OP_MUL) begin
      mre = mre >> 16;
      mim = mim >> 16;
    end else if (op == OP_DIV) begin
      xr = br < 0 ? -br : br;
      xi = bi < 0 ? -bi : bi;
      dv = xr * xr + xi * xi;
      if (dv == 0) begin
        r.dz = 1'b1;
        nre = 1'b0;
        nim = 1'b0;
        mre = '1;
        mim = '1;
      end else begin
        mre = scaled_quotient(mre, dv);
        mim = scaled_quotient(mim, dv);
      end
    end
    r.re = clamp(nre, mre, ovf);
    r.im = clamp(nim, mim, ovf);
    r.ovf = ovf;
    return r;
  endfunction

  assign pending_o = result_q.size();

  always @(posedge clk_i) begin
    cplx_res_t want;
    int        errs;
    errs = 0;
    if (!rst_ni) begin
      fail_count_o <= 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        result_q.push_back(compute_complex(op_e'(s_axis_tuser_i), s_axis_tdata_i));
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (result_q.size() == 0) begin
          $error("Result word with none expected");
          errs++;
        end else begin
          want = result_q.pop_front();
          if (want.re !== m_axis_tdata_i[31:0]) begin
            $error("res_re expected %h actual %h", want.re, m_axis_tdata_i[31:0]);
            errs++;
          end
          if (want.im !== m_axis_tdata_i[63:32]) begin
            $error("res_im expected %h actual %h", want.im, m_axis_tdata_i[63:32]);
            errs++;
          end
          if (want.ovf !== m_axis_tuser_i[0]) begin
            $error("overflow expected %b actual %b", want.ovf, m_axis_tuser_i[0]);
            errs++;
          end
          if (want.dz !== m_axis_tuser_i[1]) begin
            $error("div_zero expected %b actual %b", want.dz, m_axis_tuser_i[1]);
            errs++;
          end
        end
      end
      fail_count_o <= fail_count_o + errs;
    end
  end

endmodule

FILE: tb/sv/testbench.sv
// Testbench top of the complex arithmetic unit: stimulus, stalls and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cau_pkg::*;

  localparam int LATENCY = 38;
  localparam int N_RANDOM = 650;
  localparam int CYCLE_LIMIT = 200000;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [127:0] s_axis_tdata_i;
  logic [1:0]   s_axis_tuser_i;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  logic [63:0]  m_axis_tdata_o;
  logic [1:0]   m_axis_tuser_o;
  int           fail_count;
  int           pending;
  int           cycles;
  logic         hold_off;

  complex_arith_unit dut (.*);

  cau_checker chk (
    .clk_i, .rst_ni, .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o),
    .s_axis_tdata_i, .s_axis_tuser_i, .m_axis_tvalid_i(m_axis_tvalid_o),
    .m_axis_tready_i, .m_axis_tdata_i(m_axis_tdata_o), .m_axis_tuser_i(m_axis_tuser_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic logic [31:0] pick_part();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return 32'($signed($urandom_range(0, 8)) - 4) << 16;
      4, 5: return 32'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000);
      6: return 32'($signed($urandom_range(0, 32'h7FFFFF)) - 32'sh400000);
      default: return $urandom();
    endcase
  endfunction

  // Receiver: random stalls, a clear stretch, and one long hold-off.
  initial begin
    int mode;
    m_axis_tready_i = 1'b0;
    mode = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) m_axis_tready_i <= 1'b0;
      else begin
        if ($urandom_range(0, 49) == 0) mode = $urandom_range(0, 2);
        case (mode)
          0: m_axis_tready_i <= 1'b1;
          1: m_axis_tready_i <= ($urandom_range(0, 3) != 0);
          default: m_axis_tready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    hold_off = 1'b0;
    @(posedge rst_ni);
    repeat (300) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (200) @(posedge clk_i);
    hold_off = 1'b0;
  end

  task automatic send_word(op_e op, logic [31:0] ar, logic [31:0] ai,
                           logic [31:0] br, logic [31:0] bi);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= {bi, br, ai, ar};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic idle_gap();
    int gap;
    gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin
    int burst;
    logic [31:0] ext[4];
    ext = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0001_0000};
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int op = 0; op < 4; op++) begin
      send_word(op_e'(op), ext[0], ext[0], ext[0], ext[0]);
      send_word(op_e'(op), ext[1], ext[1], ext[1], ext[1]);
      send_word(op_e'(op), ext[0], ext[1], ext[1], ext[0]);
      send_word(op_e'(op), ext[3], ext[1], ext[3], ext[0]);
      send_word(op_e'(op), ext[1], ext[0], ext[2], ext[2]);
    end
    send_word(OP_DIV, ext[2], ext[2], ext[2], ext[2]);
    send_word(OP_DIV, ext[1], ext[0], 32'h1, 32'h0);
    send_word(OP_DIV, 32'hFFFF_FFFF, 32'h1, 32'h0, 32'hFFFF_FFFF);
    send_word(OP_MUL, 32'hFFFF_FFFF, 32'h1, 32'h1, 32'hFFFF_FFFF);
    for (int n = 0; n < N_RANDOM; n += burst) begin
      burst = $urandom_range(1, 20);
      for (int k = 0; k < burst; k++) begin
        send_word(op_e'($urandom_range(0, 3)), pick_part(), pick_part(),
                  ($urandom_range(0, 19) == 0) ? 32'h0 : pick_part(),
                  ($urandom_range(0, 19) == 0) ? 32'h0 : pick_part());
      end
      idle_gap();
    end
    s_axis_tvalid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
